FILE: sv/fct_pkg.sv
// ----------------------------------------------------------------------------
// Frustum cull tester package
// Shared types, widths and codes for the frustum culling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

    localparam int NUM_PLANES = 6;
    localparam int REG_COUNT  = 6;

    localparam int PLANE_W  = 64;
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int KIND_W   = 2;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int OFF_W    = COORD_W + 15;
    localparam int DIST_W   = PROD_W + 2;

    localparam int ADDR_W = $clog2(REG_COUNT * 8);
    localparam int IDX_W  = ADDR_W - 3;

    localparam int S_TDATA_W = ((6 * COORD_W + RADIUS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 8;

    localparam logic [KIND_W-1:0] KIND_POINT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOX    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [COORD_W-1:0]  lo_x;
        logic signed [COORD_W-1:0]  lo_y;
        logic signed [COORD_W-1:0]  lo_z;
        logic signed [COORD_W-1:0]  hi_x;
        logic signed [COORD_W-1:0]  hi_y;
        logic signed [COORD_W-1:0]  hi_z;
        logic [RADIUS_W-1:0]        sphere_radius;
    } item_t;

    typedef struct packed {
        item_t item;
        logic  in_frustum;
    } beat_t;

    typedef struct packed {
        logic [NUM_PLANES-1:0] we;
        logic [PLANE_W-1:0]    data;
    } cfg_wr_t;

endpackage

`default_nettype wire

FILE: sv/fct_apb.sv
// ----------------------------------------------------------------------------
// Frustum cull tester register port
// Decodes APB writes into per-cell plane loads and returns plane read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_apb (
    input  wire logic                                        psel,
    input  wire logic                                        penable,
    input  wire logic                                        pwrite,
    input  wire logic [fct_pkg::ADDR_W-1:0]                  paddr,
    input  wire logic [fct_pkg::PLANE_W-1:0]                 pwdata,
    output logic [fct_pkg::PLANE_W-1:0]                      prdata,
    output logic                                             pready,
    input  wire logic [fct_pkg::NUM_PLANES-1:0][fct_pkg::PLANE_W-1:0] planes,
    output fct_pkg::cfg_wr_t                                 cfg_wr
);

    logic [fct_pkg::IDX_W-1:0] idx;
    logic                      wr;

    assign idx    = paddr[fct_pkg::ADDR_W-1:3];
    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_comb begin
        cfg_wr.data = pwdata;
        cfg_wr.we   = '0;
        prdata      = '0;
        for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            if (i < fct_pkg::REG_COUNT && idx == fct_pkg::IDX_W'(i)) begin
                cfg_wr.we[i] = wr;
                prdata       = planes[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/fct_cell.sv
// ----------------------------------------------------------------------------
// Frustum cull tester plane cell
// Holds one plane, tests the passing primitive against it over two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fct_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [fct_pkg::PLANE_W-1:0]   cfg_data,
    output logic [fct_pkg::PLANE_W-1:0]        plane_q,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire fct_pkg::beat_t                in_beat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output fct_pkg::beat_t                     out_beat
);

    logic [fct_pkg::PLANE_W-1:0] plane_reg;

    logic                 v1_reg, v1_next;
    logic                 v2_reg, v2_next;
    logic                 en2;
    fct_pkg::beat_t       beat1_reg;
    fct_pkg::beat_t       beat2_reg;

    logic signed [fct_pkg::COORD_W-1:0] nx, ny, nz, d;
    logic signed [fct_pkg::COORD_W-1:0] px, py, pz;
    logic                               is_box;
    logic signed [fct_pkg::PROD_W-1:0]  prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [fct_pkg::PROD_W-1:0]  prod_x_next, prod_y_next, prod_z_next;
    logic signed [fct_pkg::OFF_W-1:0]   off_reg, off_next;
    logic signed [fct_pkg::DIST_W-1:0]  dist_sum;

    assign plane_q = plane_reg;
    assign nx = plane_reg[15:0];
    assign ny = plane_reg[31:16];
    assign nz = plane_reg[47:32];
    assign d  = plane_reg[63:48];

    assign en2      = !v2_reg || out_ready;
    assign in_ready = !v1_reg || en2;
    assign v1_next  = in_ready ? in_valid : v1_reg;
    assign v2_next  = en2 ? v1_reg : v2_reg;

    always_comb begin
        is_box = (in_beat.item.kind == fct_pkg::KIND_BOX);
        px = (is_box && !nx[15]) ? in_beat.item.hi_x : in_beat.item.lo_x;
        py = (is_box && !ny[15]) ? in_beat.item.hi_y : in_beat.item.lo_y;
        pz = (is_box && !nz[15]) ? in_beat.item.hi_z : in_beat.item.lo_z;
        prod_x_next = nx * px;
        prod_y_next = ny * py;
        prod_z_next = nz * pz;
        off_next = $signed({d[15], d, 14'd0});
        if (in_beat.item.kind == fct_pkg::KIND_SPHERE) begin
            off_next = off_next + $signed({2'b00, in_beat.item.sphere_radius, 14'd0});
        end
    end

    assign dist_sum = fct_pkg::DIST_W'(prod_x_reg) + fct_pkg::DIST_W'(prod_y_reg)
                    + fct_pkg::DIST_W'(prod_z_reg) + fct_pkg::DIST_W'(off_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                plane_reg <= cfg_data;
            end
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            beat1_reg  <= in_beat;
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            off_reg    <= off_next;
        end
        if (en2) begin
            beat2_reg.item       <= beat1_reg.item;
            beat2_reg.in_frustum <= beat1_reg.in_frustum & ~dist_sum[fct_pkg::DIST_W-1];
        end
    end

    assign out_valid = v2_reg;
    assign out_beat  = beat2_reg;

    a_plane_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> plane_reg == $past(cfg_data))
        else $error("plane register did not take the written value");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (v1_reg && v2_reg))
        else $error("cell refused a beat with a free stage");

    a_outside_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (en2 && v1_reg && !beat1_reg.in_frustum) |=> !beat2_reg.in_frustum)
        else $error("rejected primitive became inside");

endmodule

`default_nettype wire

FILE: sv/frustum_cull_tester.sv
// ----------------------------------------------------------------------------
// Frustum cull tester
// Tests points, spheres and boxes against a chain of frustum plane cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_        in         tuser: kind; tdata: lo_x, lo_y, lo_z, hi_x, hi_y, hi_z,
//                      sphere_radius
// m_        out        tdata: inside_res
// APB       in/out     six 64-bit plane registers at byte addresses 8*i
//
// One beat is accepted per cycle while the result side keeps up.
// Each plane cell registers its products, then sums and compares. Reset
// clears all planes to zero and empties the chain.
// A stalled result side backs up cell by cell; empty stages still take beats.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_cull_tester (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, sphere_radius, zero pad
    input  wire logic [fct_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind
    input  wire logic [fct_pkg::KIND_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // inside_res, zero pad
    output logic [fct_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [fct_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [fct_pkg::PLANE_W-1:0]       pwdata,
    output logic [fct_pkg::PLANE_W-1:0]            prdata,
    output logic                                   pready
);

    fct_pkg::cfg_wr_t cfg_wr;
    logic [fct_pkg::NUM_PLANES-1:0][fct_pkg::PLANE_W-1:0] planes;

    logic           valid_c [fct_pkg::NUM_PLANES+1];
    logic           ready_c [fct_pkg::NUM_PLANES+1];
    fct_pkg::beat_t beat_c  [fct_pkg::NUM_PLANES+1];

    fct_apb u_apb (
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes),
        .cfg_wr  (cfg_wr)
    );

    always_comb begin
        beat_c[0].item.kind          = s_tuser;
        beat_c[0].item.lo_x          = s_tdata[15:0];
        beat_c[0].item.lo_y          = s_tdata[31:16];
        beat_c[0].item.lo_z          = s_tdata[47:32];
        beat_c[0].item.hi_x          = s_tdata[63:48];
        beat_c[0].item.hi_y          = s_tdata[79:64];
        beat_c[0].item.hi_z          = s_tdata[95:80];
        beat_c[0].item.sphere_radius = s_tdata[110:96];
        beat_c[0].in_frustum         = 1'b1;
    end

    assign valid_c[0] = s_tvalid;
    assign s_tready   = ready_c[0];

    for (genvar i = 0; i < fct_pkg::NUM_PLANES; i++) begin : g_cell
        fct_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg_we    (cfg_wr.we[i]),
            .cfg_data  (cfg_wr.data),
            .plane_q   (planes[i]),
            .in_valid  (valid_c[i]),
            .in_ready  (ready_c[i]),
            .in_beat   (beat_c[i]),
            .out_valid (valid_c[i+1]),
            .out_ready (ready_c[i+1]),
            .out_beat  (beat_c[i+1])
        );
    end

    assign m_tvalid = valid_c[fct_pkg::NUM_PLANES];
    assign ready_c[fct_pkg::NUM_PLANES] = m_tready;
    assign m_tdata  = {{(fct_pkg::M_TDATA_W-1){1'b0}},
                       beat_c[fct_pkg::NUM_PLANES].in_frustum};

endmodule

`default_nettype wire

FILE: test/frustum_cull_tester_test.sv
// ----------------------------------------------------------------------------
// Frustum cull tester testbench
// Streams points, spheres and boxes into the culling pipeline under several
// plane settings, and checks every inside flag against a predictor. The
// predictor keeps its own copy of the six planes, written over APB. Both
// stream sides idle at random, first the sender lightly and the receiver
// heavily, then the other way round, then not at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frustum_cull_tester_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 24;
    localparam int BLOCK_ITEMS = 64;
    localparam logic [fct_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef enum int {
        PL_AXIS,
        PL_TILTED,
        PL_RANDOM,
        PL_EXTREME,
        PL_ALL_ONES,
        PL_ZERO,
        PL_COUNT
    } plane_set_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, sphere_radius, zero pad
    logic [fct_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    // kind
    logic [fct_pkg::KIND_W-1:0]      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // inside_res, zero pad
    logic [fct_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [fct_pkg::ADDR_W-1:0]      paddr = '0;
    logic [fct_pkg::PLANE_W-1:0]     pwdata = '0;
    logic [fct_pkg::PLANE_W-1:0]     prdata;
    logic                            pready;

    logic [fct_pkg::PLANE_W-1:0]     plane_shadow [fct_pkg::NUM_PLANES];
    logic                            inside_flags_due [$];
    logic                            due_flag;
    int                              mismatch_count = 0;
    int                              cycle_count = 0;
    int                              send_idle_pct = 18;
    int                              recv_idle_pct = 71;

    frustum_cull_tester dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("frustum_cull_tester_test: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (inside_flags_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("result beat with nothing due: inside %0d", m_tdata[0]);
                mismatch_count++;
            end else begin
                due_flag = inside_flags_due.pop_front();
                if (m_tdata[0] !== due_flag) begin
                    if (mismatch_count < 10)
                        $display("inside mismatch: expected %0d, got %0d",
                                 due_flag, m_tdata[0]);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic cull_verdict(fct_pkg::item_t it);
        logic signed [fct_pkg::COORD_W-1:0] nx, ny, nz, off, px, py, pz;
        longint dist_sum, bound;
        logic in_frustum;
        in_frustum = 1'b1;
        bound = (it.kind == fct_pkg::KIND_SPHERE) ?
                -(longint'(it.sphere_radius) * 16384) : 0;
        for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
            {off, nz, ny, nx} = plane_shadow[i];
            px = it.lo_x;
            py = it.lo_y;
            pz = it.lo_z;
            if (it.kind == fct_pkg::KIND_BOX) begin
                px = nx[fct_pkg::COORD_W-1] ? it.lo_x : it.hi_x;
                py = ny[fct_pkg::COORD_W-1] ? it.lo_y : it.hi_y;
                pz = nz[fct_pkg::COORD_W-1] ? it.lo_z : it.hi_z;
            end
            dist_sum = longint'(nx) * longint'(px) + longint'(ny) * longint'(py)
                     + longint'(nz) * longint'(pz) + longint'(off) * 16384;
            if (dist_sum < bound)
                in_frustum = 1'b0;
        end
        return in_frustum;
    endfunction

    function automatic fct_pkg::item_t make_item(logic [fct_pkg::KIND_W-1:0] kind,
                                                 logic [15:0] lx, logic [15:0] ly,
                                                 logic [15:0] lz, logic [15:0] hx,
                                                 logic [15:0] hy, logic [15:0] hz,
                                                 logic [fct_pkg::RADIUS_W-1:0] radius);
        fct_pkg::item_t it;
        it.kind = kind;
        it.lo_x = lx;
        it.lo_y = ly;
        it.lo_z = lz;
        it.hi_x = hx;
        it.hi_y = hy;
        it.hi_z = hz;
        it.sphere_radius = radius;
        return it;
    endfunction

    function automatic int random_coord(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int box_upper(int lo, int span);
        int hi;
        hi = lo + int'($urandom_range(0, span / 2));
        return (hi > 32767) ? 32767 : hi;
    endfunction

    // Most items are well formed near the frustum; a quarter is raw noise.
    function automatic fct_pkg::item_t random_item(int span);
        fct_pkg::item_t it;
        int lx, ly, lz;
        if ($urandom_range(0, 3) == 0) begin
            it = make_item(fct_pkg::KIND_W'($urandom_range(0, 3)),
                           16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom),
                           fct_pkg::RADIUS_W'($urandom));
        end else begin
            lx = random_coord(span);
            ly = random_coord(span);
            lz = random_coord(span);
            it = make_item(fct_pkg::KIND_W'($urandom_range(0, 2)),
                           16'(lx), 16'(ly), 16'(lz),
                           16'($urandom), 16'($urandom), 16'($urandom),
                           fct_pkg::RADIUS_W'($urandom));
            if (it.kind == fct_pkg::KIND_BOX) begin
                it.hi_x = 16'(box_upper(lx, span));
                it.hi_y = 16'(box_upper(ly, span));
                it.hi_z = 16'(box_upper(lz, span));
            end else if (it.kind == fct_pkg::KIND_SPHERE) begin
                it.sphere_radius = fct_pkg::RADIUS_W'($urandom_range(0, span / 2));
            end
        end
        return it;
    endfunction

    function automatic logic [fct_pkg::PLANE_W-1:0] plane_word(logic [15:0] nx,
                                                               logic [15:0] ny,
                                                               logic [15:0] nz,
                                                               logic [15:0] off);
        return {off, nz, ny, nx};
    endfunction

    task automatic send_item(fct_pkg::item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {{(fct_pkg::S_TDATA_W - 6 * fct_pkg::COORD_W - fct_pkg::RADIUS_W){1'b0}},
                     it.sphere_radius,
                     it.hi_z, it.hi_y, it.hi_x, it.lo_z, it.lo_y, it.lo_x};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        inside_flags_due.push_back(cull_verdict(it));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (inside_flags_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(int index, logic [fct_pkg::PLANE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fct_pkg::ADDR_W'(index * 8);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index < fct_pkg::REG_COUNT)
            plane_shadow[index] = value;
        @(posedge aclk);
    endtask

    task automatic load_planes(plane_set_t set);
        logic [fct_pkg::PLANE_W-1:0] words [fct_pkg::NUM_PLANES];
        case (set)
            PL_AXIS: begin
                words[0] = plane_word(16'h4000, 16'h0000, 16'h0000, 16'h0A00);
                words[1] = plane_word(16'hC000, 16'h0000, 16'h0000, 16'h0A00);
                words[2] = plane_word(16'h0000, 16'h4000, 16'h0000, 16'h0A00);
                words[3] = plane_word(16'h0000, 16'hC000, 16'h0000, 16'h0A00);
                words[4] = plane_word(16'h0000, 16'h0000, 16'h4000, 16'h0200);
                words[5] = plane_word(16'h0000, 16'h0000, 16'hC000, 16'h1400);
            end
            PL_TILTED: begin
                words[0] = plane_word(16'h2D41, 16'h0000, 16'h2D41, 16'h0400);
                words[1] = plane_word(16'hD2BF, 16'h0000, 16'h2D41, 16'h0400);
                words[2] = plane_word(16'h0000, 16'h2D41, 16'h2D41, 16'h0400);
                words[3] = plane_word(16'h0000, 16'hD2BF, 16'h2D41, 16'h0400);
                words[4] = plane_word(16'h0000, 16'h0000, 16'h4000, 16'hFF00);
                words[5] = plane_word(16'h0000, 16'h0000, 16'hC000, 16'h1000);
            end
            PL_EXTREME: begin
                words[0] = plane_word(16'h8000, 16'h8000, 16'h8000, 16'h8000);
                words[1] = plane_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                words[2] = plane_word(16'h8000, 16'h7FFF, 16'h0000, 16'h8000);
                words[3] = plane_word(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
                words[4] = plane_word(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
                words[5] = plane_word(16'h0000, 16'h0000, 16'h8000, 16'h8000);
            end
            PL_ALL_ONES: begin
                foreach (words[i]) words[i] = '1;
            end
            PL_ZERO: begin
                foreach (words[i]) words[i] = '0;
            end
            default: begin
                foreach (words[i]) words[i] = {$urandom, $urandom};
            end
        endcase
        for (int i = 0; i < fct_pkg::NUM_PLANES; i++)
            apb_write(i, words[i]);
    endtask

    // With every plane cleared each distance is zero, so nothing is rejected.
    task automatic test_cleared_planes();
        send_item(make_item(fct_pkg::KIND_POINT, 16'h8000, 16'h8000, 16'h8000,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF));
        send_item(make_item(fct_pkg::KIND_SPHERE, 16'h7FFF, 16'h8000, 16'h7FFF,
                            16'h0000, 16'h0000, 16'h0000, 15'h0000));
        send_item(make_item(fct_pkg::KIND_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h8000, 16'h8000, 16'h8000, 15'h0000));
        wait_drained();
    endtask

    // Axis frustum: x and y within ten units, z from minus two to twenty.
    task automatic test_directed_cases();
        load_planes(PL_AXIS);
        send_item(make_item(fct_pkg::KIND_POINT, 16'h0000, 16'h0000, 16'h0000,
                            16'hFFFF, 16'h8000, 16'h7FFF, 15'h7FFF));
        send_item(make_item(fct_pkg::KIND_POINT, 16'hF600, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 15'h0000));
        send_item(make_item(fct_pkg::KIND_POINT, 16'hF5FF, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 15'h0000));
        send_item(make_item(fct_pkg::KIND_POINT, 16'h0000, 16'h0000, 16'h1E00,
                            16'h0000, 16'h0000, 16'h0000, 15'h0000));
        send_item(make_item(fct_pkg::KIND_POINT, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h8000, 16'h8000, 16'h8000, 15'h0000));
        send_item(make_item(fct_pkg::KIND_POINT, 16'h8000, 16'h8000, 16'h8000,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0000));
        send_item(make_item(fct_pkg::KIND_SPHERE, 16'hF400, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 15'h0200));
        send_item(make_item(fct_pkg::KIND_SPHERE, 16'hF400, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 15'h01FF));
        send_item(make_item(fct_pkg::KIND_SPHERE, 16'h8000, 16'h8000, 16'h8000,
                            16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF));
        send_item(make_item(fct_pkg::KIND_SPHERE, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 15'h0000));
        send_item(make_item(fct_pkg::KIND_BOX, 16'hEC00, 16'h0000, 16'h0000,
                            16'h0000, 16'h0100, 16'h0100, 15'h7FFF));
        send_item(make_item(fct_pkg::KIND_BOX, 16'hEC00, 16'h0000, 16'h0000,
                            16'hF500, 16'h0100, 16'h0100, 15'h0000));
        send_item(make_item(fct_pkg::KIND_BOX, 16'h0500, 16'h0000, 16'h0000,
                            16'hFB00, 16'h0100, 16'h0100, 15'h0000));
        send_item(make_item(fct_pkg::KIND_BOX, 16'h0F00, 16'h0000, 16'h0000,
                            16'hF100, 16'h0100, 16'h0100, 15'h0000));
        send_item(make_item(fct_pkg::KIND_BOX, 16'h8000, 16'h8000, 16'h8000,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0000));
        send_item(make_item(fct_pkg::KIND_BOX, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h0000));
        send_item(make_item(KIND_SPARE, 16'h0000, 16'h0000, 16'h0000,
                            16'h8000, 16'h8000, 16'h8000, 15'h7FFF));
        send_item(make_item(KIND_SPARE, 16'hF5FF, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 15'h7FFF));
        wait_drained();
    endtask

    // Writes above the last plane must leave every plane untouched.
    task automatic test_ignored_writes();
        apb_write(fct_pkg::REG_COUNT, '1);
        apb_write(fct_pkg::REG_COUNT + 1, '1);
        send_item(make_item(fct_pkg::KIND_POINT, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 15'h0000));
        send_item(make_item(fct_pkg::KIND_SPHERE, 16'h0000, 16'h0000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 15'h0000));
        send_item(make_item(fct_pkg::KIND_BOX, 16'hFF00, 16'hFF00, 16'h0000,
                            16'h0100, 16'h0100, 16'h0100, 15'h0000));
        wait_drained();
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, int first_set,
                                       int blocks);
        plane_set_t set;
        int span;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int b = 0; b < blocks; b++) begin
            set = plane_set_t'((first_set + b) % PL_COUNT);
            span = (set == PL_AXIS || set == PL_TILTED) ? 4096 : 32767;
            load_planes(set);
            repeat (BLOCK_ITEMS) send_item(random_item(span));
            wait_drained();
        end
    endtask

    initial begin
        foreach (plane_shadow[i]) plane_shadow[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_cleared_planes();
        test_directed_cases();
        test_ignored_writes();
        test_random_traffic(18, 71, 0, 5);
        test_random_traffic(71, 18, 5, 5);
        test_random_traffic(0, 0, 10, 5);
        if (mismatch_count == 0) begin
            $display("frustum_cull_tester_test: done, clean");
        end else begin
            $display("frustum_cull_tester_test: done, errors");
        end
        $finish;
    end

endmodule

FILE: frustum_cull_tester.f
sv/fct_pkg.sv
sv/fct_apb.sv
sv/fct_cell.sv
sv/frustum_cull_tester.sv
test/frustum_cull_tester_test.sv
